// ===== src/stq_pkg.sv =====
// Types and constants shared by the sorted timer queue.
`timescale 1ns / 1ps
package stq_pkg;

    localparam int FUNC_W = 2;
    localparam int DLY_W  = 20;
    localparam int ID_W   = 31;
    localparam int HND_W  = 16;
    localparam int DUE_W  = 32;
    localparam int ST_W   = 3;
    localparam int MAX_OUT = 32;
    localparam int K_W    = $clog2(MAX_OUT + 1);

    // Item kinds
    localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CANCEL = 2'd2;

    // Result status codes
    localparam logic [ST_W-1:0] ST_ADDED     = 3'd0;
    localparam logic [ST_W-1:0] ST_BAD_DELAY = 3'd1;
    localparam logic [ST_W-1:0] ST_FULL      = 3'd2;
    localparam logic [ST_W-1:0] ST_CANCELLED = 3'd3;
    localparam logic [ST_W-1:0] ST_BAD_ID    = 3'd4;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd5;
    localparam logic [ST_W-1:0] ST_EXPIRED   = 3'd6;
    localparam logic [ST_W-1:0] ST_NONE      = 3'd7;

    localparam logic [ID_W-1:0]  ID_MAX   = '1;
    localparam logic [DUE_W-1:0] TIME_MAX = '1;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [DLY_W-1:0]  delay_seconds;
        logic [ID_W-1:0]   cancel_id;
        logic [HND_W-1:0]  job_handle;
    } t_in_item;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [ID_W-1:0]  timer_id;
        logic [HND_W-1:0] handle_out;
        logic [DUE_W-1:0] due_time;
        logic             last;
    } t_out_item;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [DUE_W-1:0] due;
        logic [HND_W-1:0] handle;
    } t_entry;

endpackage

// ===== src/stq_chan_if.sv =====
// Valid/ready channels for command and result items.
`timescale 1ns / 1ps
interface stq_in_if;
    import stq_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item item;
    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface stq_out_if;
    import stq_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item item;
    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

// ===== src/stq_ram.sv =====
// Timer entry store: one write port, one registered read port.
`timescale 1ns / 1ps
module stq_ram #(
    parameter int AW = 5
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  stq_pkg::t_entry  i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output stq_pkg::t_entry  o_rdata
);
    import stq_pkg::*;

    t_entry r_mem [2**AW];
    t_entry r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== src/sorted_timer_queue_top.sv =====
// Sorted timer queue: ring of timer entries in one RAM, sorted by due second.
// Rejects are answered straight from idle; an add reads and moves each later-due entry up one slot.
// Cancel reads every entry held. Tick pops expired entries from the head until one is not yet due,
// the queue empties or the burst limit is hit. One item at a time; the next is taken once
// the last result is offered and the receiver is ready. Output stalls hold the queue back.
// Reset (synchronous, active low) empties the queue and zeroes clock and id counter.
`timescale 1ns / 1ps
module sorted_timer_queue_top #(
    parameter int CAPACITY   = 32,
    parameter int DELAY_BITS = 20
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    stq_in_if.sink    i_cmd,
    stq_out_if.source o_res
);
    import stq_pkg::*;

    localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int N_W = $clog2(CAPACITY + 1);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_A_RD  = 8'b0000_0010,
        S_A_WR  = 8'b0000_0100,
        S_C_RD  = 8'b0000_1000,
        S_C_CHK = 8'b0001_0000,
        S_T_RD  = 8'b0010_0000,
        S_T_CHK = 8'b0100_0000,
        S_T_END = 8'b1000_0000
    } t_state;

    t_state           r_state, n_state;
    logic [DUE_W-1:0] r_now, n_now;
    logic [ID_W-1:0]  r_next_id, n_next_id;
    logic [N_W-1:0]   r_n, n_n;
    logic [AW-1:0]    r_head, n_head;
    logic [N_W-1:0]   r_idx, n_idx;
    logic [K_W-1:0]   r_k, n_k;
    logic             r_found, n_found;
    t_entry           r_new, n_new;
    logic [ID_W-1:0]  r_cid, n_cid;
    t_out_item        r_pend, n_pend;
    logic             r_pend_v, n_pend_v;
    t_out_item        r_out, n_out;
    logic             r_out_v, n_out_v;

    logic             we, re;
    logic [AW-1:0]    waddr, raddr;
    t_entry           wdata, rdata;
    logic             out_free, accept;
    logic             too_wide;
    logic [DUE_W:0]   due_sum;
    logic [DUE_W-1:0] due_new;
    logic [ID_W-1:0]  id_new;
    logic [AW-1:0]    a_idx, a_prev;
    t_in_item         cmd;

    stq_ram #(.AW(AW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign cmd      = i_cmd.item;
    assign out_free = !r_out_v || o_res.ready;
    assign accept   = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready = (r_state == S_IDLE) && out_free;
    assign o_res.valid = r_out_v;
    assign o_res.item  = r_out;

    // add checks and derived values
    assign too_wide = (DELAY_BITS < DLY_W) ?
                      ((cmd.delay_seconds >> DELAY_BITS) != '0) : 1'b0;
    assign due_sum  = {1'b0, r_now} + {{(DUE_W + 1 - DLY_W){1'b0}}, cmd.delay_seconds};
    assign due_new  = due_sum[DUE_W] ? TIME_MAX : due_sum[DUE_W-1:0];
    assign id_new   = (r_next_id >= ID_MAX) ? ID_W'(1) : r_next_id + ID_W'(1);

    // ring addresses of the current and previous logical slot
    assign a_idx  = AW'(r_head + r_idx[AW-1:0]);
    assign a_prev = AW'(r_head + r_idx[AW-1:0] - AW'(1));

    always_comb begin
        n_state   = r_state;
        n_now     = r_now;
        n_next_id = r_next_id;
        n_n       = r_n;
        n_head    = r_head;
        n_idx     = r_idx;
        n_k       = r_k;
        n_found   = r_found;
        n_new     = r_new;
        n_cid     = r_cid;
        n_pend    = r_pend;
        n_pend_v  = r_pend_v;
        n_out     = r_out;
        n_out_v   = r_out_v && !o_res.ready;
        we        = 1'b0;
        re        = 1'b0;
        waddr     = a_idx;
        wdata     = r_new;
        raddr     = a_idx;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_out = '0;
                    n_out.last = 1'b1;
                    case (cmd.func)
                        FUNC_TICK: begin
                            if (r_now != TIME_MAX) begin
                                n_now = r_now + DUE_W'(1);
                            end
                            n_k      = '0;
                            n_pend_v = 1'b0;
                            n_state  = S_T_RD;
                        end
                        FUNC_ADD: begin
                            if (cmd.delay_seconds == '0 || too_wide) begin
                                n_out.status = ST_BAD_DELAY;
                                n_out_v      = 1'b1;
                            end else if (r_n == N_W'(CAPACITY)) begin
                                n_out.status = ST_FULL;
                                n_out_v      = 1'b1;
                            end else begin
                                n_next_id  = id_new;
                                n_new.id     = id_new;
                                n_new.due    = due_new;
                                n_new.handle = cmd.job_handle;
                                n_idx      = r_n;
                                n_state    = S_A_RD;
                            end
                        end
                        FUNC_CANCEL: begin
                            if (cmd.cancel_id == '0) begin
                                n_out.status = ST_BAD_ID;
                                n_out_v      = 1'b1;
                            end else begin
                                n_cid   = cmd.cancel_id;
                                n_idx   = '0;
                                n_found = 1'b0;
                                n_state = S_C_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            // insertion: walk down from the tail, moving later-due entries up
            S_A_RD: begin
                if (r_idx == '0) begin
                    we    = 1'b1;
                    n_n   = r_n + N_W'(1);
                    n_out = '{status: ST_ADDED, timer_id: r_new.id, handle_out: '0,
                              due_time: r_new.due, last: 1'b1};
                    n_out_v = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    re      = 1'b1;
                    raddr   = a_prev;
                    n_state = S_A_WR;
                end
            end

            S_A_WR: begin
                we = 1'b1;
                if (rdata.due > r_new.due) begin
                    wdata   = rdata;
                    n_idx   = r_idx - N_W'(1);
                    n_state = S_A_RD;
                end else begin
                    n_n   = r_n + N_W'(1);
                    n_out = '{status: ST_ADDED, timer_id: r_new.id, handle_out: '0,
                              due_time: r_new.due, last: 1'b1};
                    n_out_v = 1'b1;
                    n_state = S_IDLE;
                end
            end

            // cancel: find first match, then close the gap behind it
            S_C_RD: begin
                if (r_idx == r_n) begin
                    n_out = '0;
                    n_out.last = 1'b1;
                    if (r_found) begin
                        n_n            = r_n - N_W'(1);
                        n_out.status   = ST_CANCELLED;
                        n_out.timer_id = r_cid;
                    end else begin
                        n_out.status = ST_NOT_FOUND;
                    end
                    n_out_v = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    re      = 1'b1;
                    n_state = S_C_CHK;
                end
            end

            S_C_CHK: begin
                if (r_found) begin
                    we    = 1'b1;
                    waddr = a_prev;
                    wdata = rdata;
                end else if (rdata.id == r_cid) begin
                    n_found = 1'b1;
                end
                n_idx   = r_idx + N_W'(1);
                n_state = S_C_RD;
            end

            // tick: pop expired entries from the head
            S_T_RD: begin
                if (r_n == '0 || r_k == K_W'(MAX_OUT)) begin
                    n_state = S_T_END;
                end else begin
                    re      = 1'b1;
                    raddr   = r_head;
                    n_state = S_T_CHK;
                end
            end

            S_T_CHK: begin
                if (rdata.due <= r_now) begin
                    if (!r_pend_v || out_free) begin
                        if (r_pend_v) begin
                            n_out   = r_pend;
                            n_out_v = 1'b1;
                        end
                        n_pend = '{status: ST_EXPIRED, timer_id: rdata.id,
                                   handle_out: rdata.handle, due_time: rdata.due,
                                   last: 1'b0};
                        n_pend_v = 1'b1;
                        n_head   = r_head + AW'(1);
                        n_n      = r_n - N_W'(1);
                        n_k      = r_k + K_W'(1);
                        n_state  = S_T_RD;
                    end
                end else begin
                    n_state = S_T_END;
                end
            end

            S_T_END: begin
                if (out_free) begin
                    if (r_pend_v) begin
                        n_out      = r_pend;
                        n_out.last = 1'b1;
                    end else begin
                        n_out        = '0;
                        n_out.status = ST_NONE;
                        n_out.last   = 1'b1;
                    end
                    n_out_v  = 1'b1;
                    n_pend_v = 1'b0;
                    n_state  = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_now     <= '0;
            r_next_id <= '0;
            r_n       <= '0;
            r_head    <= '0;
            r_pend_v  <= 1'b0;
            r_out_v   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_now     <= n_now;
            r_next_id <= n_next_id;
            r_n       <= n_n;
            r_head    <= n_head;
            r_pend_v  <= n_pend_v;
            r_out_v   <= n_out_v;
        end
    end

    // working registers and payload
    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_k     <= n_k;
        r_found <= n_found;
        r_new   <= n_new;
        r_cid   <= n_cid;
        r_pend  <= n_pend;
        r_out   <= n_out;
    end
endmodule

// ===== tb/testbench.sv =====
// Self-checking bench for the sorted timer queue: random commands, predicted results.
`timescale 1ns / 1ps
module testbench;
    import stq_pkg::*;

    localparam int CAP = 32;
    localparam int LIMIT_CYCLES = 2000000;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    logic i_clk;
    logic i_rst_n;

    stq_in_if  cmd_if ();
    stq_out_if res_if ();

    sorted_timer_queue_top #(.CAPACITY(CAP), .DELAY_BITS(20)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    // Predictor state
    logic [DUE_W-1:0] pred_now = '0;
    logic [ID_W-1:0]  pred_next_id = '0;
    t_entry           timer_list[$];

    t_in_item  pending_cmds[$];
    t_out_item expected_results[$];

    int  n_errors = 0;
    int  n_results = 0;
    int  n_expired = 0;
    int  n_full = 0;
    int  cycles;
    int  hold_off;
    int  hold_wait;
    int  gap_cnt;
    int  stall_cnt;
    logic [ID_W-1:0] issued_ids[$];

    // Expected results of one accepted command
    task automatic predict_results(input t_in_item c);
        t_out_item r;
        t_entry    e;
        logic [DUE_W:0] sum;
        int pos;
        int k;
        bit found;
        r = '0;
        r.last = 1'b1;
        case (c.func)
            FUNC_TICK: begin
                if (pred_now != TIME_MAX) pred_now = pred_now + DUE_W'(1);
                k = 0;
                while (timer_list.size() > 0 && k < MAX_OUT &&
                       timer_list[0].due <= pred_now) begin
                    e = timer_list.pop_front();
                    r.status = ST_EXPIRED;
                    r.timer_id = e.id;
                    r.handle_out = e.handle;
                    r.due_time = e.due;
                    r.last = 1'b0;
                    expected_results.push_back(r);
                    k++;
                end
                if (k == 0) begin
                    r.status = ST_NONE;
                    r.last = 1'b1;
                    expected_results.push_back(r);
                end else begin
                    expected_results[$].last = 1'b1;
                end
            end
            FUNC_ADD: begin
                if (c.delay_seconds == '0) begin
                    r.status = ST_BAD_DELAY;
                end else if (timer_list.size() >= CAP) begin
                    r.status = ST_FULL;
                end else begin
                    pred_next_id = (pred_next_id >= ID_MAX) ? ID_W'(1)
                                                            : pred_next_id + ID_W'(1);
                    sum = {1'b0, pred_now} + c.delay_seconds;
                    e.id = pred_next_id;
                    e.due = sum[DUE_W] ? TIME_MAX : sum[DUE_W-1:0];
                    e.handle = c.job_handle;
                    pos = 0;
                    while (pos < timer_list.size() && timer_list[pos].due <= e.due) pos++;
                    timer_list.insert(pos, e);
                    issued_ids.push_back(e.id);
                    r.status = ST_ADDED;
                    r.timer_id = e.id;
                    r.due_time = e.due;
                end
                expected_results.push_back(r);
            end
            FUNC_CANCEL: begin
                found = 1'b0;
                if (c.cancel_id == '0) begin
                    r.status = ST_BAD_ID;
                end else begin
                    for (int i = 0; i < timer_list.size() && !found; i++) begin
                        if (timer_list[i].id == c.cancel_id) begin
                            timer_list.delete(i);
                            found = 1'b1;
                        end
                    end
                    r.status = found ? ST_CANCELLED : ST_NOT_FOUND;
                    r.timer_id = found ? c.cancel_id : '0;
                end
                expected_results.push_back(r);
            end
            default: ;
        endcase
    endtask

    function automatic t_in_item make_cmd(input logic [FUNC_W-1:0] f,
                                          input logic [DLY_W-1:0] d,
                                          input logic [ID_W-1:0] id,
                                          input logic [HND_W-1:0] h);
        t_in_item c;
        c.func = f;
        c.delay_seconds = d;
        c.cancel_id = id;
        c.job_handle = h;
        return c;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [ID_W-1:0] pick_cancel_id();
        int p;
        p = $urandom_range(0, 9);
        if (p < 6 && issued_ids.size() > 0)
            return issued_ids[$urandom_range(0, issued_ids.size() - 1)];
        if (p < 8) return ID_W'($urandom);
        return ID_W'($urandom_range(1, 200));
    endfunction

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Stimulus
    initial begin
        t_in_item c;
        int p;
        i_rst_n = 1'b0;
        // Directed: extremes and each special case
        pending_cmds.push_back(make_cmd(FUNC_TICK, '0, '0, '0));
        pending_cmds.push_back(make_cmd(FUNC_ADD, '0, '0, 16'h1234));
        pending_cmds.push_back(make_cmd(FUNC_ADD, 20'd1, ID_MAX, '1));
        pending_cmds.push_back(make_cmd(FUNC_ADD, '1, '0, 16'h0001));
        pending_cmds.push_back(make_cmd(FUNC_ADD, 20'd2, '0, 16'hA5A5));
        pending_cmds.push_back(make_cmd(FUNC_ADD, 20'd2, '0, 16'h5A5A));
        pending_cmds.push_back(make_cmd(FUNC_CANCEL, '1, '0, '1));
        pending_cmds.push_back(make_cmd(FUNC_CANCEL, '0, ID_MAX, '0));
        pending_cmds.push_back(make_cmd(FUNC_CANCEL, '0, 31'd2, '0));
        pending_cmds.push_back(make_cmd(FUNC_UNUSED, '1, '1, '1));
        pending_cmds.push_back(make_cmd(FUNC_TICK, '0, '0, '0));
        pending_cmds.push_back(make_cmd(FUNC_TICK, '1, '1, '1));
        pending_cmds.push_back(make_cmd(FUNC_TICK, '0, '0, '0));
        // Fill the store past capacity, then drain with one burst
        for (int i = 0; i < CAP + 2; i++)
            pending_cmds.push_back(make_cmd(FUNC_ADD, 20'd1, '0, 16'(i)));
        pending_cmds.push_back(make_cmd(FUNC_TICK, '0, '0, '0));
        pending_cmds.push_back(make_cmd(FUNC_TICK, '0, '0, '0));
        // Random mix: mostly adds with short delays, ticks and cancels
        for (int i = 0; i < 75; i++) begin
            p = $urandom_range(0, 99);
            c.delay_seconds = ($urandom_range(0, 9) == 0) ? DLY_W'($urandom)
                                                          : DLY_W'($urandom_range(0, 6));
            c.cancel_id = pick_cancel_id();
            c.job_handle = HND_W'($urandom);
            if (p < 45) c.func = FUNC_ADD;
            else if (p < 75) c.func = FUNC_TICK;
            else if (p < 97) c.func = FUNC_CANCEL;
            else c.func = FUNC_UNUSED;
            pending_cmds.push_back(c);
        end
        for (int i = 0; i < 8; i++) pending_cmds.push_back(make_cmd(FUNC_TICK, '0, '0, '0));
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Long receiver hold-off while commands keep coming
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_off  <= 0;
            hold_wait <= 60;
        end else if (hold_wait > 0) begin
            hold_wait <= hold_wait - 1;
            if (hold_wait == 1) hold_off <= 300;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
        end
    end

    // Driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
            cmd_if.item  <= '0;
            gap_cnt      <= 0;
        end else begin
            if (cmd_if.valid && cmd_if.ready) begin
                predict_results(cmd_if.item);
                void'(pending_cmds.pop_front());
            end
            if (cmd_if.valid && !cmd_if.ready) begin
                // hold item
            end else if (gap_cnt > 0) begin
                gap_cnt <= gap_cnt - 1;
                cmd_if.valid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
                cmd_if.item <= pending_cmds[0];
                cmd_if.valid <= 1'b1;
                gap_cnt <= pick_gap();
            end else begin
                cmd_if.valid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            stall_cnt    <= 0;
        end else if (hold_off > 0) begin
            res_if.ready <= 1'b0;
        end else if (stall_cnt > 0) begin
            stall_cnt <= stall_cnt - 1;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
            stall_cnt <= pick_gap();
        end
    end

    // Monitor and scoreboard
    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item got;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got = res_if.item;
            n_results++;
            if (got.status == ST_EXPIRED) n_expired++;
            if (got.status == ST_FULL) n_full++;
            if (expected_results.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected result %p", got);
            end else begin
                want = expected_results.pop_front();
                if (got.status !== want.status || got.timer_id !== want.timer_id ||
                    got.handle_out !== want.handle_out ||
                    got.due_time !== want.due_time || got.last !== want.last) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("result mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    // Cycle limit and end of run
    initial begin
        cycles = 0;
        @(posedge i_rst_n);
        while ((pending_cmds.size() > 0 || expected_results.size() > 0) &&
               cycles < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycles++;
        end
        if (cycles >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            repeat (200) @(posedge i_clk);
            $display("%0d results checked, %0d expiries, %0d full rejects",
                     n_results, n_expired, n_full);
            if (n_errors == 0 && expected_results.size() == 0) begin
                $display("SCOREBOARD CLEAN");
            end else begin
                $display("%0d mismatches", n_errors);
                $display("SCOREBOARD MISMATCH");
            end
            $finish;
        end
    end

endmodule
